// ===== sv/ipd_pkg.sv =====
// Shared types, character constants and header table for the IPD frame parser.
`timescale 1ns / 1ps

package ipd_pkg;

  // Default width of the announced payload length
  localparam int LenWidthDef = 16;

  // Header "+IPD," length and match index width
  localparam int          HdrIdxW = 3;
  localparam logic [2:0]  HdrLen  = 3'd5;

  // Characters of interest
  localparam logic [7:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [7:0] ChI     = 8'h49;  // 'I'
  localparam logic [7:0] ChP     = 8'h50;  // 'P'
  localparam logic [7:0] ChD     = 8'h44;  // 'D'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChColon = 8'h3A;  // ':'
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Parser phase
  typedef enum logic [1:0] {
    PhSearch  = 2'd0,
    PhChannel = 2'd1,
    PhLength  = 2'd2,
    PhPayload = 2'd3
  } phase_t;

  // Payload byte classification
  typedef enum logic [1:0] {
    KindData     = 2'd0,
    KindCr       = 2'd1,
    KindLineDone = 2'd2,
    KindFrameErr = 2'd3
  } kind_t;

  // Header character at a given match position
  function automatic logic [7:0] hdr_char(input logic [HdrIdxW-1:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = ChPlus;
      3'd1:    ch = ChI;
      3'd2:    ch = ChP;
      3'd3:    ch = ChD;
      3'd4:    ch = ChComma;
      default: ch = ChPlus;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/ipd_frame_payload_parser_core.sv =====
// Top level: "+IPD,<channel>,<length>:<payload>" receive frame parser.
`timescale 1ns / 1ps

// Takes one received byte per beat on the in_ channel and emits one beat on the
// out_ channel for every payload byte, tagged as data, CR terminator, LF line
// completion or framing error, with out_frame_last on the byte that uses up the
// announced length. Header, channel and length bytes produce no output beat.
// The length saturates at 2**LEN_WIDTH - 1; a zero length returns straight to
// header search. Throughput is one byte per cycle unless a payload byte is stalled:
// each byte goes from the input register through a single small state update into
// the output register. The input register lets the next byte be taken while a
// result waits in the output register; only a payload byte that finds the output
// register full and stalled holds the input side.
module ipd_frame_payload_parser_core #(
  parameter int LEN_WIDTH = ipd_pkg::LenWidthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  // input byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // payload output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_kind,
  output logic       out_frame_last
);

  import ipd_pkg::*;

  localparam int MulW = LEN_WIDTH + 4;

  // input register
  logic                 in_valid_r;
  logic [7:0]           in_byte_r;

  // parser state
  phase_t               phase_r,     phase_nxt;
  logic [HdrIdxW-1:0]   match_idx_r, match_idx_nxt;
  logic [LEN_WIDTH-1:0] remaining_r, remaining_nxt;
  logic                 digits_done_r, digits_done_nxt;
  logic                 expect_lf_r, expect_lf_nxt;

  // output register
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  kind_t                out_kind_r;
  logic                 out_last_r;

  // combinational result
  logic                 res_valid;
  kind_t                res_kind;
  logic                 res_last;
  logic [LEN_WIDTH-1:0] rem_dec;
  logic [MulW-1:0]      len_x10;
  logic                 out_free;
  logic                 advance;

  // Handshake: a byte leaves the input register unless it needs a full output slot
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && ((phase_r != PhPayload) || out_free);
  assign in_stall = in_valid_r && !advance;

  // length * 10 + digit, four bits wider than the length so it cannot overflow
  assign len_x10 = ({4'b0000, remaining_r} << 3) + ({4'b0000, remaining_r} << 1)
                 + {{(MulW-4){1'b0}}, in_byte_r[3:0]};

  assign rem_dec = (remaining_r != '0) ? remaining_r - 1'b1 : remaining_r;

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt       = phase_r;
    match_idx_nxt   = match_idx_r;
    remaining_nxt   = remaining_r;
    digits_done_nxt = digits_done_r;
    expect_lf_nxt   = expect_lf_r;
    res_valid       = 1'b0;
    res_kind        = KindData;
    res_last        = 1'b0;
    case (phase_r)
      PhSearch: begin
        if (match_idx_r < HdrLen && in_byte_r == hdr_char(match_idx_r)) begin
          if (match_idx_r == HdrLen - 3'd1) begin
            phase_nxt     = PhChannel;
            match_idx_nxt = '0;
          end else begin
            match_idx_nxt = match_idx_r + 3'd1;
          end
        end else begin
          // a stray '+' may start a new header
          match_idx_nxt = (in_byte_r == ChPlus) ? 3'd1 : 3'd0;
        end
      end
      PhChannel: begin
        if (in_byte_r == ChComma) begin
          phase_nxt       = PhLength;
          remaining_nxt   = '0;
          digits_done_nxt = 1'b0;
        end
      end
      PhLength: begin
        if (in_byte_r == ChColon) begin
          if (remaining_r == '0) begin
            phase_nxt     = PhSearch;
            match_idx_nxt = '0;
            expect_lf_nxt = 1'b0;
          end else begin
            phase_nxt = PhPayload;
          end
        end else if (!digits_done_r && (in_byte_r inside {[ChZero:ChNine]})) begin
          // saturating decimal accumulate
          if (len_x10 > {4'b0000, {LEN_WIDTH{1'b1}}}) begin
            remaining_nxt = '1;
          end else begin
            remaining_nxt = len_x10[LEN_WIDTH-1:0];
          end
        end else begin
          digits_done_nxt = 1'b1;
        end
      end
      PhPayload: begin
        res_valid = 1'b1;
        if (in_byte_r == ChCr) begin
          if (!expect_lf_r) begin
            res_kind      = KindCr;
            expect_lf_nxt = 1'b1;
          end else begin
            res_kind = KindFrameErr;
          end
        end else if (in_byte_r == ChLf) begin
          if (expect_lf_r) begin
            res_kind      = KindLineDone;
            expect_lf_nxt = 1'b0;
          end else begin
            res_kind = KindFrameErr;
          end
        end
        remaining_nxt = rem_dec;
        res_last      = (rem_dec == '0);
        if (res_last) begin
          phase_nxt     = PhSearch;
          match_idx_nxt = '0;
          expect_lf_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = PhSearch;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || advance) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PhSearch;
      match_idx_r   <= '0;
      remaining_r   <= '0;
      digits_done_r <= 1'b0;
      expect_lf_r   <= 1'b0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      match_idx_r   <= match_idx_nxt;
      remaining_r   <= remaining_nxt;
      digits_done_r <= digits_done_nxt;
      expect_lf_r   <= expect_lf_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_byte_r <= in_byte_r;
      out_kind_r <= res_kind;
      out_last_r <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_byte_r;
  assign out_kind       = out_kind_r;
  assign out_frame_last = out_last_r;

`ifndef NO_ASSERTIONS
  // header match index never runs past the header
  a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
    match_idx_r < HdrLen)
    else $error("header match index out of range");

  // match index is only live while searching
  a_match_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PhSearch |-> match_idx_r == '0)
    else $error("match index set outside header search");

  // no pending LF while searching for a header
  a_lf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PhSearch |-> !expect_lf_r)
    else $error("expect_lf set during header search");

  // payload phase always has bytes left
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PhPayload |-> remaining_r != '0)
    else $error("payload phase with zero length");

  // a payload byte that moves on always lands in the output register
  a_payload_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == PhPayload |=> out_valid_r && out_byte_r == $past(in_byte_r))
    else $error("payload byte lost");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the IPD frame parser: framed byte streams against a scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import ipd_pkg::*;

  localparam int          CycleLimit  = 1000000;
  localparam int          DrainCycles = 40;
  localparam int          RandItems   = 850;
  localparam int          SatTail     = 24;
  localparam logic [39:0] HdrText     = {ChPlus, ChI, ChP, ChD, ChComma};
  localparam logic [31:0] LenMax      = (32'd1 << LenWidthDef) - 32'd1;

  // How the length field of a generated frame is spelled
  typedef enum int {
    LenPlain,
    LenPadded,
    LenStopped,
    LenEmpty
  } len_style_t;

  // One expected payload beat
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } beat_t;

  // Tracks the parser state from accepted bytes and checks payload beats in order
  class payload_scoreboard;
    phase_t                 cur_phase;
    logic [HdrIdxW-1:0]     hdr_pos;
    logic [LenWidthDef-1:0] len_left;
    bit                     digits_stopped;
    bit                     lf_pending;
    beat_t                  beats_due[$];
    int                     errors;

    function new();
      cur_phase      = PhSearch;
      hdr_pos        = '0;
      len_left       = '0;
      digits_stopped = 1'b0;
      lf_pending     = 1'b0;
      errors         = 0;
    endfunction

    function void to_search();
      cur_phase  = PhSearch;
      hdr_pos    = '0;
      lf_pending = 1'b0;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    // Advance the tracked state by one accepted byte
    function void note_byte(logic [7:0] b);
      logic [31:0] next_len;
      beat_t       beat;
      case (cur_phase)
        PhSearch: begin
          if (hdr_pos < HdrLen && b == HdrText[39 - 8 * int'(hdr_pos) -: 8]) begin
            hdr_pos = hdr_pos + 1'b1;
            if (hdr_pos >= HdrLen) begin
              cur_phase = PhChannel;
              hdr_pos   = '0;
            end
          end else begin
            // a stray '+' may start a new header
            hdr_pos = (b == ChPlus) ? 3'd1 : 3'd0;
          end
        end
        PhChannel: begin
          if (b == ChComma) begin
            cur_phase      = PhLength;
            len_left       = '0;
            digits_stopped = 1'b0;
          end
        end
        PhLength: begin
          if (b == ChColon) begin
            if (len_left == 0) to_search();
            else cur_phase = PhPayload;
          end else if (!digits_stopped && b >= ChZero && b <= ChNine) begin
            next_len = 32'(len_left) * 32'd10 + 32'(b - ChZero);
            len_left = (next_len > LenMax) ? LenMax[LenWidthDef-1:0]
                                           : next_len[LenWidthDef-1:0];
          end else begin
            digits_stopped = 1'b1;
          end
        end
        default: begin
          beat.data = b;
          if (b == ChCr) begin
            if (!lf_pending) begin
              beat.kind  = KindCr;
              lf_pending = 1'b1;
            end else begin
              beat.kind = KindFrameErr;
            end
          end else if (b == ChLf) begin
            if (lf_pending) begin
              beat.kind  = KindLineDone;
              lf_pending = 1'b0;
            end else begin
              beat.kind = KindFrameErr;
            end
          end else begin
            beat.kind = KindData;
          end
          if (len_left != 0) len_left = len_left - 1'b1;
          beat.last = (len_left == 0);
          beats_due.push_back(beat);
          if (beat.last) to_search();
        end
      endcase
    endfunction

    // Compare one output beat with the oldest expectation
    function void check_beat(logic [7:0] data, logic [1:0] kind, logic last);
      beat_t want;
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: data=%h kind=%0d last=%b", data, kind, last);
        return;
      end
      want = beats_due.pop_front();
      if (data !== want.data || kind !== want.kind || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want data=%h kind=%0d last=%b, got data=%h kind=%0d last=%b",
                   want.data, want.kind, want.last, data, kind, last);
      end
    endfunction
  endclass

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte     = 8'h00;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_data_byte;
  logic [1:0] out_kind;
  logic       out_frame_last;

  payload_scoreboard sb;
  logic [7:0]        tx_q[$];
  bit                quiet      = 1'b0;
  int                items_sent = 0;
  int                cycle_cnt  = 0;
  int                stall_left = 0;

  ipd_frame_payload_parser_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_kind       (out_kind),
    .out_frame_last (out_frame_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) sb.note_byte(in_rx_byte);
      if (out_valid === 1'b1 && !out_stall)
        sb.check_beat(out_data_byte, out_kind, out_frame_last);
    end
  end

  // Offer one byte and hold it until taken
  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic flush_q();
    while (tx_q.size() > 0) put_byte(tx_q.pop_front());
  endtask

  // Stop sending until every expected beat is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_q.push_back(8'(s[i]));
  endtask

  function automatic logic [7:0] rand_byte_except(input bit no_digit, input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == avoid || (no_digit && b >= ChZero && b <= ChNine));
    return b;
  endfunction

  // Payload content leans on CR and LF to exercise line tracking
  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return ChCr;
    if (r < 6) return ChLf;
    return 8'($urandom_range(0, 255));
  endfunction

  // Full frame: header, channel, length field, colon, payload
  task automatic gen_frame(input int len, input len_style_t style);
    push_text("+IPD,");
    repeat ($urandom_range(0, 3))
      tx_q.push_back(($urandom_range(0, 3) == 0) ? rand_byte_except(1'b0, ChComma)
                                                 : 8'(ChZero + $urandom_range(0, 9)));
    tx_q.push_back(ChComma);
    case (style)
      LenPlain:  push_text($sformatf("%0d", len));
      LenPadded: push_text($sformatf("00%0d", len));
      LenStopped: begin
        push_text($sformatf("%0d", len));
        tx_q.push_back(rand_byte_except(1'b1, ChColon));
        repeat ($urandom_range(0, 3)) tx_q.push_back(rand_byte_except(1'b0, ChColon));
      end
      default: begin
        // no digits at all, so the length stays zero
        repeat ($urandom_range(0, 2)) tx_q.push_back(rand_byte_except(1'b1, ChColon));
      end
    endcase
    tx_q.push_back(ChColon);
    repeat (len) tx_q.push_back(payload_byte());
    flush_q();
  endtask

  // Header prefix broken off by a wrong byte
  task automatic gen_broken_header();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) tx_q.push_back(HdrText[39 - 8 * i -: 8]);
    tx_q.push_back(rand_byte_except(1'b0, HdrText[39 - 8 * n -: 8]));
    flush_q();
  endtask

  // Stimulus
  initial begin
    int         rand_goal;
    int         r;
    bit         paused;
    len_style_t style;
    sb     = new();
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // double '+' restart, stop char after digits, all four kinds, byte extremes
    push_text("++IPD,,7x:");
    tx_q.push_back(ChCr);
    tx_q.push_back(ChCr);
    tx_q.push_back(ChLf);
    tx_q.push_back(ChLf);
    tx_q.push_back(8'h00);
    tx_q.push_back(8'hFF);
    tx_q.push_back(ChCr);
    // zero length, then an LF that must not close the earlier CR
    push_text("+IPD,,:");
    push_text("+IPD,,1:");
    tx_q.push_back(ChLf);
    tx_q.push_back(8'hFF);
    tx_q.push_back(8'h00);
    flush_q();

    // random frames, mixed with noise and broken headers
    rand_goal = items_sent + RandItems;
    while (items_sent < rand_goal) begin
      quiet = ($urandom_range(0, 9) == 0);
      if (!paused && items_sent > rand_goal - RandItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r     = $urandom_range(0, 99);
      style = len_style_t'($urandom_range(0, 2));
      if (r < 70) begin
        gen_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                  style);
      end else if (r < 78) begin
        gen_frame(0, ($urandom_range(0, 1) == 0) ? style : LenEmpty);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom_range(0, 255)));
        flush_q();
      end else begin
        gen_broken_header();
      end
    end
    quiet = 1'b0;
    wait_drained();

    // length past the counter range saturates, so none of this tail ends the frame;
    // a wrapped length would be 19 and end the frame inside it. Run it without idling.
    quiet = 1'b1;
    push_text("+IPD,1,655379:");
    repeat (SatTail) tx_q.push_back(payload_byte());
    flush_q();
    quiet = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
